/* sv/mbpa_pkg.sv */
// Package of the hierarchical bitmap page allocator: types, constants, helpers.
// No dependencies.
`default_nettype none
package mbpa_pkg;

  localparam int unsigned MaxPages   = 16384;
  localparam int unsigned MaxRequest = 64;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned MapWords   = MaxPages / WordBits;
  localparam int unsigned PageW      = $clog2(MaxPages);
  localparam int unsigned WordAddrW  = $clog2(MapWords);
  localparam int unsigned LenW       = 15;
  localparam int unsigned FrameW     = 40;
  localparam int unsigned VirtW      = 36;
  localparam int unsigned CountW     = 7;
  localparam int unsigned MinLen     = 10;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_BADFR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BASE = 2'd0,
    REG_LEN  = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    LV_PAGE  = 2'd0,
    LV_QUAD  = 2'd1,
    LV_OCTET = 2'd2,
    LV_HEX   = 2'd3
  } level_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SEL, S_RD, S_CHK, S_EMIT, S_WB, S_FRD, S_FCHK
  } state_e;

  typedef logic [PageW-1:0] cnt_t;
  typedef cnt_t [3:0] lv_cnt_t;

  typedef struct packed {
    logic       found;
    logic [5:0] off;
  } blk_t;

  // usable pages for a programmed length, saturated to the legal range
  function automatic cnt_t usable(input logic [LenW-1:0] len);
    logic [LenW-1:0] l;
    l = len;
    if (l < LenW'(MinLen)) l = LenW'(MinLen);
    if (l > LenW'(MaxPages)) l = LenW'(MaxPages);
    return PageW'(l - LenW'(1));
  endfunction

  function automatic lv_cnt_t init_counts(input cnt_t u);
    lv_cnt_t c;
    logic [PageW:0] w;
    w = {1'b0, u};
    c[0] = u;
    c[1] = PageW'((w + (PageW+1)'(3)) >> 2);
    c[2] = PageW'((w + (PageW+1)'(7)) >> 3);
    c[3] = PageW'((w + (PageW+1)'(15)) >> 4);
    return c;
  endfunction

  // whole group of the level around bit off is free
  function automatic logic group_zero(input logic [63:0] word, input logic [5:0] off,
                                      input level_e lv);
    logic z;
    unique case (lv)
      LV_PAGE:  z = (word[off] == 1'b0);
      LV_QUAD:  z = (word[{off[5:2], 2'b00} +: 4] == 4'd0);
      LV_OCTET: z = (word[{off[5:3], 3'b000} +: 8] == 8'd0);
      LV_HEX:   z = (word[{off[5:4], 4'b0000} +: 16] == 16'd0);
      default:  z = 1'b0;
    endcase
    return z;
  endfunction

  function automatic logic aligned(input logic [5:0] off, input level_e lv);
    logic a;
    unique case (lv)
      LV_PAGE:  a = 1'b1;
      LV_QUAD:  a = (off[1:0] == 2'd0);
      LV_OCTET: a = (off[2:0] == 3'd0);
      LV_HEX:   a = (off[3:0] == 4'd0);
      default:  a = 1'b0;
    endcase
    return a;
  endfunction

  // lowest free block of the level inside one map word
  function automatic blk_t find_block(input logic [63:0] word, input level_e lv,
                                      input logic [WordAddrW-1:0] widx, input cnt_t u);
    blk_t r;
    logic [5:0] o;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      o = 6'(i);
      if (aligned(o, lv) && ({widx, o} < u) && group_zero(word, o, lv)) begin
        r.found = 1'b1;
        r.off   = o;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] block_pages(input level_e lv);
    logic [4:0] g;
    unique case (lv)
      LV_PAGE:  g = 5'd1;
      LV_QUAD:  g = 5'd4;
      LV_OCTET: g = 5'd8;
      LV_HEX:   g = 5'd16;
      default:  g = 5'd1;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* sv/mbpa_if.sv */
// Request, response and register-write channel interfaces of the allocator.
// Depends on mbpa_pkg.
`default_nettype none
interface mbpa_req_if import mbpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [CountW-1:0]     count;
  logic [VirtW-1:0]      virt_page;
  logic [FrameW-1:0]     free_frame;
  modport source(output valid, func, count, virt_page, free_frame, input ready);
  modport sink(input valid, func, count, virt_page, free_frame, output ready);
endinterface

interface mbpa_rsp_if import mbpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [FrameW-1:0]     phys_frame;
  logic [VirtW-1:0]      mapped_virt_page;
  logic                  last;
  logic [PageW-1:0]      free_pages;
  modport source(output valid, status, phys_frame, mapped_virt_page, last, free_pages,
                 input ready);
  modport sink(input valid, status, phys_frame, mapped_virt_page, last, free_pages,
               output ready);
endinterface

interface mbpa_cfg_if import mbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [FrameW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/mbpa_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mbpa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/multilevel_bitmap_page_allocator.sv */
// Hierarchical bitmap page allocator, one request at a time. A refused allocate or an
// out-of-range free is answered from the dispatch state, and a free reads its map word and
// answers from the check state. An allocate selects the coarsest level with a free block,
// scans map words from word 0 (read, check), emits one response per page and writes the word
// back per block. A stalled response holds the machine. Reset (async, active low) and a base
// or length register write mark every map row empty; no clearing pass.
`default_nettype none
module multilevel_bitmap_page_allocator import mbpa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbpa_req_if.sink   req_i,
  mbpa_rsp_if.source rsp_o,
  mbpa_cfg_if.sink   cfg_i
);
  // Only the page map is stored: a coarse bit always equals the OR of the
  // pages of its group, so coarser maps are derived from the page word.

  state_e state_q, state_d;
  logic [FrameW-1:0] base_q, base_d;
  cnt_t ulen_q, ulen_d;
  lv_cnt_t lvc_q, lvc_d;
  cnt_t ft_q, ft_d;
  logic [MapWords-1:0] rowv_q, rowv_d;
  logic rvalid_q;

  // request payload
  logic func_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [VirtW-1:0] virt_q;
  logic [FrameW-1:0] ff_q;

  // walk state
  logic [CountW-1:0] k_q, k_d;
  cnt_t page_q, page_d;
  logic [PageW:0] blkend_q, blkend_d;
  level_e lv_q, lv_d;
  logic [63:0] word_q, word_d;
  logic [WordAddrW-1:0] addr_q, addr_d;
  cnt_t fpa_q, fpa_d;

  // response register
  logic out_v_q, out_v_d;
  logic [1:0] o_st_q, o_st_d;
  logic [FrameW-1:0] o_pf_q, o_pf_d;
  logic [VirtW-1:0] o_vp_q, o_vp_d;
  logic o_last_q, o_last_d;
  cnt_t o_fp_q, o_fp_d;

  logic ram_we;
  logic [63:0] ram_wdata, ram_rdata, rd_word;
  logic slot_free, emit;
  logic cfg_fire, req_fire;
  blk_t blk;
  logic [CountW-1:0] cnt_sat;
  logic [FrameW-1:0] fdiff;
  logic [PageW:0] nxt_page;
  logic [63:0] fmask;
  cnt_t u_new;

  mbpa_ram #(.Width(64), .Depth(MapWords)) u_page_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_word   = rvalid_q ? ram_rdata : '0;
  assign slot_free = !out_v_q || rsp_o.ready;
  assign cfg_i.ready = (state_q == S_IDLE);
  assign req_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign req_fire  = req_i.valid && req_i.ready;

  assign rsp_o.valid            = out_v_q;
  assign rsp_o.status           = o_st_q;
  assign rsp_o.phys_frame       = o_pf_q;
  assign rsp_o.mapped_virt_page = o_vp_q;
  assign rsp_o.last             = o_last_q;
  assign rsp_o.free_pages       = o_fp_q;

  assign cnt_sat  = (cnt_q > CountW'(MaxRequest)) ? CountW'(MaxRequest) : cnt_q;
  assign fdiff    = ff_q - base_q - FrameW'(1);
  assign blk      = find_block(rd_word, lv_q, addr_q, ulen_q);
  assign nxt_page = {1'b0, page_q} + (PageW+1)'(1);
  assign fmask    = 64'(1) << page_q[5:0];
  assign u_new    = usable(cfg_i.data[LenW-1:0]);

  always_comb begin
    state_d = state_q;
    base_d = base_q;
    ulen_d = ulen_q;
    lvc_d = lvc_q;
    ft_d = ft_q;
    rowv_d = rowv_q;
    cnt_d = cnt_q;
    k_d = k_q;
    page_d = page_q;
    blkend_d = blkend_q;
    lv_d = lv_q;
    word_d = word_q;
    addr_d = addr_q;
    fpa_d = fpa_q;
    ram_we = 1'b0;
    ram_wdata = word_q;
    emit = 1'b0;
    o_st_d = o_st_q;
    o_pf_d = o_pf_q;
    o_vp_d = o_vp_q;
    o_last_d = o_last_q;
    o_fp_d = o_fp_q;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          // any defined register write re-initializes the region
          if (cfg_i.index == REG_BASE) begin
            base_d = cfg_i.data;
            lvc_d  = init_counts(ulen_q);
            ft_d   = ulen_q;
            rowv_d = '0;
          end else if (cfg_i.index == REG_LEN) begin
            ulen_d = u_new;
            lvc_d  = init_counts(u_new);
            ft_d   = u_new;
            rowv_d = '0;
          end
        end else if (req_fire) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (func_q) begin
          if ((ff_q <= base_q) || (fdiff >= FrameW'(ulen_q))) begin
            if (slot_free) begin
              emit = 1'b1;
              o_st_d = ST_BADFR; o_pf_d = ff_q; o_vp_d = '0;
              o_last_d = 1'b1; o_fp_d = ft_q;
              state_d = S_IDLE;
            end
          end else begin
            page_d  = fdiff[PageW-1:0];
            addr_d  = fdiff[PageW-1:6];
            state_d = S_FRD;
          end
        end else if (cnt_q == '0 || ft_q < PageW'(cnt_sat)) begin
          if (slot_free) begin
            emit = 1'b1;
            o_st_d = (cnt_q == '0) ? ST_OK : ST_NOMEM;
            o_pf_d = '0; o_vp_d = '0; o_last_d = 1'b1; o_fp_d = ft_q;
            state_d = S_IDLE;
          end
        end else begin
          cnt_d   = cnt_sat;
          fpa_d   = ft_q - PageW'(cnt_sat);
          k_d     = '0;
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        // coarsest level with a free block; scan from the first word
        if (lvc_q[3] != '0)      lv_d = LV_HEX;
        else if (lvc_q[2] != '0) lv_d = LV_OCTET;
        else if (lvc_q[1] != '0) lv_d = LV_QUAD;
        else                     lv_d = LV_PAGE;
        addr_d  = '0;
        state_d = S_RD;
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (blk.found) begin
          word_d   = rd_word;
          page_d   = {addr_q, blk.off};
          blkend_d = {1'b0, addr_q, blk.off} + (PageW+1)'(block_pages(lv_q));
          state_d  = S_EMIT;
        end else begin
          addr_d  = addr_q + WordAddrW'(1);
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          o_st_d = ST_OK;
          o_pf_d = base_q + FrameW'(1) + FrameW'(page_q);
          o_vp_d = virt_q + VirtW'(k_q);
          o_last_d = (k_q + CountW'(1) == cnt_q);
          o_fp_d = fpa_q;
          if (lvc_q[0] != '0) lvc_d[0] = lvc_q[0] - PageW'(1);
          for (int l = 1; l < 4; l++) begin
            if (group_zero(word_q, page_q[5:0], level_e'(l)) && lvc_q[l] != '0) begin
              lvc_d[l] = lvc_q[l] - PageW'(1);
            end
          end
          word_d = word_q | fmask;
          ft_d   = ft_q - PageW'(1);
          k_d    = k_q + CountW'(1);
          page_d = nxt_page[PageW-1:0];
          if ((k_q + CountW'(1) == cnt_q) || (nxt_page == blkend_q) ||
              (nxt_page == {1'b0, ulen_q})) begin
            state_d = S_WB;
          end
        end
      end
      S_WB: begin
        ram_we = 1'b1;
        ram_wdata = word_q;
        rowv_d[addr_q] = 1'b1;
        state_d = (k_q == cnt_q) ? S_IDLE : S_SEL;
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        if (slot_free) begin
          emit = 1'b1;
          o_pf_d = ff_q; o_vp_d = '0; o_last_d = 1'b1;
          state_d = S_IDLE;
          if ((rd_word & fmask) == '0) begin
            o_st_d = ST_BADFR;
            o_fp_d = ft_q;
          end else begin
            ram_we = 1'b1;
            ram_wdata = rd_word & ~fmask;
            rowv_d[addr_q] = 1'b1;
            lvc_d[0] = lvc_q[0] + PageW'(1);
            for (int l = 1; l < 4; l++) begin
              if (group_zero(rd_word & ~fmask, page_q[5:0], level_e'(l)) &&
                  !group_zero(rd_word, page_q[5:0], level_e'(l))) begin
                lvc_d[l] = lvc_q[l] + PageW'(1);
              end
            end
            ft_d = ft_q + PageW'(1);
            o_st_d = ST_OK;
            o_fp_d = ft_q + PageW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_v_d = emit || (out_v_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      base_q   <= '0;
      ulen_q   <= PageW'(MaxPages - 1);
      lvc_q    <= init_counts(PageW'(MaxPages - 1));
      ft_q     <= PageW'(MaxPages - 1);
      rowv_q   <= '0;
      rvalid_q <= 1'b0;
      out_v_q  <= 1'b0;
      k_q      <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      ulen_q   <= ulen_d;
      lvc_q    <= lvc_d;
      ft_q     <= ft_d;
      rowv_q   <= rowv_d;
      rvalid_q <= rowv_q[addr_q];
      out_v_q  <= out_v_d;
      k_q      <= k_d;
      cnt_q    <= req_fire ? req_i.count : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q <= req_i.func;
      virt_q <= req_i.virt_page;
      ff_q   <= req_i.free_frame;
    end
    page_q   <= page_d;
    blkend_q <= blkend_d;
    lv_q     <= lv_d;
    word_q   <= word_d;
    addr_q   <= addr_d;
    fpa_q    <= fpa_d;
    o_st_q   <= o_st_d;
    o_pf_q   <= o_pf_d;
    o_vp_q   <= o_vp_d;
    o_last_q <= o_last_d;
    o_fp_q   <= o_fp_d;
  end

  // page-level counter always tracks the free total
  a_lv0_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvc_q[0] == ft_q) else $error("page counter differs from free total");

  a_emit_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> k_q < cnt_q) else $error("emitting past request count");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> page_q < ulen_q) else $error("page beyond region");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_WB || state_q == S_FCHK)) else $error("stray map write");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && o_last_d && state_q == S_EMIT |=> state_q == S_WB)
    else $error("last page not written back");

endmodule
`default_nettype wire
